### design/rwl_pkg.sv
package rwl_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int MAX_RESULTS    = 16;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);
    localparam int RC_W   = 9;

    typedef logic [THREAD_ID_BITS-1:0] t_tid;
    typedef logic [QPTR_W-1:0]         t_qptr;
    typedef logic [QCNT_W-1:0]         t_qcnt;
    typedef logic [NRES_W-1:0]         t_nres;
    typedef logic [RC_W-1:0]           t_rc;

    localparam t_rc   READER_MAX  = t_rc'(511);
    localparam t_qcnt QUEUE_FULL  = t_qcnt'(QUEUE_DEPTH);
    localparam t_qptr QPTR_LAST   = t_qptr'(QUEUE_DEPTH - 1);
    localparam t_nres NRES_LAST   = t_nres'(MAX_RESULTS - 1);

    typedef enum logic [1:0] {
        KIND_RD  = 2'd0,
        KIND_WR  = 2'd1,
        KIND_REL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        EV_RD_GRANT = 3'd0,
        EV_WR_GRANT = 3'd1,
        EV_QUEUED   = 3'd2,
        EV_REJECT   = 3'd3,
        EV_REL_OK   = 3'd4,
        EV_REL_ERR  = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HAND,
        ST_RWAIT,
        ST_RGRANT
    } t_state;

    typedef enum logic [1:0] {
        RC_HOLD,
        RC_INC,
        RC_DEC
    } t_rc_op;

    // wrap-around increment of a queue pointer
    function automatic t_qptr qptr_next(input t_qptr p);
        t_qptr r;
        r = (p == QPTR_LAST) ? '0 : p + t_qptr'(1);
        return r;
    endfunction

endpackage

### design/rwl_ram.sv
module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/reader_writer_lock_arbiter_core.sv
// an acquire, or a refused release, gives its beat from the execute state, any
// other release from the handoff state; a release wakes up to sixteen readers, each
// after the first through the wait and grant states, set by the registered queue read;
// new requests wait for idle; a stalled output beat holds the sequencer where it is
// reset (i_rst_n, synchronous, active low) frees the lock, zeroes the reader count and
// empties both wait queues; queue storage is not cleared and needs no clearing pass
module reader_writer_lock_arbiter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] thread_id
    input  logic [1:0] i_s_axis_tuser,   // [1:0] kind
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] target_thread
    output logic [2:0] o_m_axis_tuser,   // [2:0] event_res
    output logic       o_m_axis_tlast    // last result of the request
);

    // sequencer and lock state
    rwl_pkg::t_state r_state, n_state;
    logic            r_wh;          // a writer owns the lock
    rwl_pkg::t_tid   r_owner;
    rwl_pkg::t_rc    r_rc;          // readers holding the lock
    rwl_pkg::t_nres  r_n;           // beats given so far for the current request

    // wait queues: head, tail and fill count per queue
    rwl_pkg::t_qptr  r_rhead, r_rtail, r_whead, r_wtail;
    rwl_pkg::t_qcnt  r_rcnt, r_wcnt;

    // latched request
    logic [1:0]      r_kind;
    rwl_pkg::t_tid   r_tid;

    // output register
    logic            r_m_valid;
    logic [7:0]      r_m_tdata;
    logic [2:0]      r_m_tuser;
    logic            r_m_tlast;

    // queue read data, addressed by the head pointers
    rwl_pkg::t_tid   rq_rdata, wq_rdata;

    // actions decided by the sequencer
    logic            emit, e_last;
    rwl_pkg::t_tid   e_tid;
    rwl_pkg::t_event e_ev;
    rwl_pkg::t_rc_op rc_op;
    logic            wh_set, wh_clr;
    logic            rpush, wpush, rpop, wpop;
    logic            done, go_hand, go_rwait;

    logic            in_beat, out_free;
    rwl_pkg::t_rc    rc_sum;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    // the one shared adder: every reader count change goes through here
    always_comb begin
        case (rc_op)
            rwl_pkg::RC_INC: rc_sum = r_rc + rwl_pkg::t_rc'(1);
            rwl_pkg::RC_DEC: rc_sum = r_rc - rwl_pkg::t_rc'(1);
            default:         rc_sum = r_rc;
        endcase
    end

    rwl_ram #(
        .WIDTH(rwl_pkg::THREAD_ID_BITS),
        .DEPTH(rwl_pkg::QUEUE_DEPTH)
    ) u_rq (
        .i_clk  (i_clk),
        .i_we   (rpush),
        .i_waddr(r_rtail),
        .i_wdata(r_tid),
        .i_raddr(r_rhead),
        .o_rdata(rq_rdata)
    );

    rwl_ram #(
        .WIDTH(rwl_pkg::THREAD_ID_BITS),
        .DEPTH(rwl_pkg::QUEUE_DEPTH)
    ) u_wq (
        .i_clk  (i_clk),
        .i_we   (wpush),
        .i_waddr(r_wtail),
        .i_wdata(r_tid),
        .i_raddr(r_whead),
        .o_rdata(wq_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rwl_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_state = rwl_pkg::ST_EXEC;
                end
            end
            rwl_pkg::ST_EXEC, rwl_pkg::ST_HAND, rwl_pkg::ST_RGRANT: begin
                if (done) begin
                    n_state = rwl_pkg::ST_IDLE;
                end else if (go_hand) begin
                    n_state = rwl_pkg::ST_HAND;
                end else if (go_rwait) begin
                    n_state = rwl_pkg::ST_RWAIT;
                end
            end
            rwl_pkg::ST_RWAIT: n_state = rwl_pkg::ST_RGRANT;
            default:           n_state = rwl_pkg::ST_IDLE;
        endcase
    end

    // sequencer actions
    always_comb begin
        emit     = 1'b0;
        e_last   = 1'b1;
        e_tid    = r_tid;
        e_ev     = rwl_pkg::EV_REL_OK;
        rc_op    = rwl_pkg::RC_HOLD;
        wh_set   = 1'b0;
        wh_clr   = 1'b0;
        rpush    = 1'b0;
        wpush    = 1'b0;
        rpop     = 1'b0;
        wpop     = 1'b0;
        done     = 1'b0;
        go_hand  = 1'b0;
        go_rwait = 1'b0;

        case (r_state)
            rwl_pkg::ST_EXEC: begin
                case (r_kind)
                    rwl_pkg::KIND_RD: begin
                        if (out_free) begin
                            emit = 1'b1;
                            done = 1'b1;
                            if (r_wh) begin
                                if (r_rcnt < rwl_pkg::QUEUE_FULL) begin
                                    rpush = 1'b1;
                                    e_ev  = rwl_pkg::EV_QUEUED;
                                end else begin
                                    e_ev  = rwl_pkg::EV_REJECT;
                                end
                            end else if (r_rc >= rwl_pkg::READER_MAX) begin
                                e_ev  = rwl_pkg::EV_REJECT;
                            end else begin
                                rc_op = rwl_pkg::RC_INC;
                                e_ev  = rwl_pkg::EV_RD_GRANT;
                            end
                        end
                    end
                    rwl_pkg::KIND_WR: begin
                        if (out_free) begin
                            emit = 1'b1;
                            done = 1'b1;
                            if (r_wh || r_rc != '0) begin
                                if (r_wcnt < rwl_pkg::QUEUE_FULL) begin
                                    wpush = 1'b1;
                                    e_ev  = rwl_pkg::EV_QUEUED;
                                end else begin
                                    e_ev  = rwl_pkg::EV_REJECT;
                                end
                            end else begin
                                wh_set = 1'b1;
                                e_ev   = rwl_pkg::EV_WR_GRANT;
                            end
                        end
                    end
                    rwl_pkg::KIND_REL: begin
                        if (r_wh && r_owner == r_tid) begin
                            wh_clr  = 1'b1;
                            go_hand = 1'b1;
                        end else if (r_rc == '0) begin
                            // release with nothing held
                            if (out_free) begin
                                emit = 1'b1;
                                e_ev = rwl_pkg::EV_REL_ERR;
                                done = 1'b1;
                            end
                        end else begin
                            rc_op   = rwl_pkg::RC_DEC;
                            go_hand = 1'b1;
                        end
                    end
                    default: done = 1'b1;
                endcase
            end
            rwl_pkg::ST_HAND, rwl_pkg::ST_RGRANT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_state == rwl_pkg::ST_HAND && !r_wh && r_wcnt != '0) begin
                        done = 1'b1;
                        // writers first, but only once all readers are gone
                        if (r_rc == '0) begin
                            e_tid  = wq_rdata;
                            e_ev   = rwl_pkg::EV_WR_GRANT;
                            wpop   = 1'b1;
                            wh_set = 1'b1;
                        end
                    end else if (r_state == rwl_pkg::ST_RGRANT ||
                                 (!r_wh && r_rcnt != '0 && r_rc < rwl_pkg::READER_MAX)) begin
                        // wake one queued reader
                        e_tid  = rq_rdata;
                        e_ev   = rwl_pkg::EV_RD_GRANT;
                        rpop   = 1'b1;
                        rc_op  = rwl_pkg::RC_INC;
                        e_last = !(r_rcnt != rwl_pkg::t_qcnt'(1) &&
                                   r_n < rwl_pkg::NRES_LAST &&
                                   r_rc < rwl_pkg::READER_MAX - rwl_pkg::t_rc'(1));
                        done     = e_last;
                        go_rwait = !e_last;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rwl_pkg::ST_IDLE;
            r_wh      <= 1'b0;
            r_owner   <= '0;
            r_rc      <= '0;
            r_n       <= '0;
            r_rhead   <= '0;
            r_rtail   <= '0;
            r_rcnt    <= '0;
            r_whead   <= '0;
            r_wtail   <= '0;
            r_wcnt    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rc    <= rc_sum;
            if (wh_set) begin
                r_wh    <= 1'b1;
                r_owner <= e_tid;
            end else if (wh_clr) begin
                r_wh <= 1'b0;
            end
            if (in_beat) begin
                r_n <= '0;
            end else if (emit) begin
                r_n <= r_n + rwl_pkg::t_nres'(1);
            end
            if (rpush) begin
                r_rtail <= rwl_pkg::qptr_next(r_rtail);
                r_rcnt  <= r_rcnt + rwl_pkg::t_qcnt'(1);
            end else if (rpop) begin
                r_rhead <= rwl_pkg::qptr_next(r_rhead);
                r_rcnt  <= r_rcnt - rwl_pkg::t_qcnt'(1);
            end
            if (wpush) begin
                r_wtail <= rwl_pkg::qptr_next(r_wtail);
                r_wcnt  <= r_wcnt + rwl_pkg::t_qcnt'(1);
            end else if (wpop) begin
                r_whead <= rwl_pkg::qptr_next(r_whead);
                r_wcnt  <= r_wcnt - rwl_pkg::t_qcnt'(1);
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_kind <= i_s_axis_tuser;
            r_tid  <= rwl_pkg::t_tid'(i_s_axis_tdata);
        end
        if (emit) begin
            r_m_tdata <= 8'(e_tid);
            r_m_tuser <= e_ev;
            r_m_tlast <= e_last;
        end
    end

    assign o_s_axis_tready = (r_state == rwl_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;
    assign o_m_axis_tlast  = r_m_tlast;

    // a writer never owns the lock while readers still hold it
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wh && r_rc != '0))
        else $error("writer and readers hold the lock together");

    // queue fill counts stay within the queue depth
    a_qcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= rwl_pkg::QUEUE_FULL && r_wcnt <= rwl_pkg::QUEUE_FULL)
        else $error("wait queue overfilled");

    // a beat is only produced into a free output slot
    a_noovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("output beat overwritten");

    // a release never wakes more readers than one request may report
    a_nres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= rwl_pkg::t_nres'(rwl_pkg::MAX_RESULTS))
        else $error("too many beats for one request");

endmodule

### tb/rwl_checker.sv
module rwl_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic [7:0]    i_req_data,     // [7:0] thread_id
    input  logic [1:0]    i_req_user,     // [1:0] kind
    input  logic          i_res_valid,
    input  logic          i_res_ready,
    input  logic [7:0]    i_res_data,     // [7:0] target_thread
    input  logic [2:0]    i_res_user,     // [2:0] event_res
    input  logic          i_res_last,
    output int            o_mismatches,
    output int            o_pending,
    output int            o_beats,
    output logic          o_writer_held,
    output rwl_pkg::t_tid o_owner
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        rwl_pkg::t_tid   target;
        rwl_pkg::t_event ev;
        logic            last;
    } t_lock_result;

    // shadow lock state
    logic          writer_locked;
    rwl_pkg::t_tid owner_tid;
    rwl_pkg::t_rc  reader_holds;
    rwl_pkg::t_tid waiting_readers[$];
    rwl_pkg::t_tid waiting_writers[$];
    t_lock_result  results_due[$];
    int            mismatches;
    int            beats_seen;

    assign o_mismatches = mismatches;
    assign o_beats      = beats_seen;

    initial begin
        mismatches = 0;
        beats_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    function automatic void add_result(input rwl_pkg::t_tid target, input rwl_pkg::t_event ev);
        t_lock_result r;
        r.target = target;
        r.ev     = ev;
        r.last   = 1'b0;
        results_due.push_back(r);
    endfunction

    task automatic predict_lock_request(input logic [1:0] kind, input rwl_pkg::t_tid tid);
        int first;
        first = results_due.size();
        case (kind)
            rwl_pkg::KIND_RD: begin
                if (writer_locked) begin
                    if (waiting_readers.size() < rwl_pkg::QUEUE_DEPTH) begin
                        waiting_readers.push_back(tid);
                        add_result(tid, rwl_pkg::EV_QUEUED);
                    end else begin
                        add_result(tid, rwl_pkg::EV_REJECT);
                    end
                end else if (reader_holds >= rwl_pkg::READER_MAX) begin
                    add_result(tid, rwl_pkg::EV_REJECT);
                end else begin
                    reader_holds = reader_holds + 1'b1;
                    add_result(tid, rwl_pkg::EV_RD_GRANT);
                end
            end
            rwl_pkg::KIND_WR: begin
                if (writer_locked || reader_holds != '0) begin
                    if (waiting_writers.size() < rwl_pkg::QUEUE_DEPTH) begin
                        waiting_writers.push_back(tid);
                        add_result(tid, rwl_pkg::EV_QUEUED);
                    end else begin
                        add_result(tid, rwl_pkg::EV_REJECT);
                    end
                end else begin
                    writer_locked = 1'b1;
                    owner_tid     = tid;
                    add_result(tid, rwl_pkg::EV_WR_GRANT);
                end
            end
            rwl_pkg::KIND_REL: begin
                if (!(writer_locked && owner_tid == tid) && reader_holds == '0) begin
                    // nothing held by this thread
                    add_result(tid, rwl_pkg::EV_REL_ERR);
                end else begin
                    if (writer_locked && owner_tid == tid)
                        writer_locked = 1'b0;
                    else
                        reader_holds = reader_holds - 1'b1;
                    if (!writer_locked && waiting_writers.size() != 0) begin
                        // waiting writer only takes over once the readers are gone
                        if (reader_holds == '0) begin
                            owner_tid     = waiting_writers.pop_front();
                            writer_locked = 1'b1;
                            add_result(owner_tid, rwl_pkg::EV_WR_GRANT);
                        end
                    end else if (!writer_locked) begin
                        while (waiting_readers.size() != 0
                               && results_due.size() - first < rwl_pkg::MAX_RESULTS
                               && reader_holds < rwl_pkg::READER_MAX) begin
                            reader_holds = reader_holds + 1'b1;
                            add_result(waiting_readers.pop_front(), rwl_pkg::EV_RD_GRANT);
                        end
                    end
                    if (results_due.size() == first)
                        add_result(tid, rwl_pkg::EV_REL_OK);
                end
            end
            default: ;
        endcase
        if (results_due.size() > first)
            results_due[results_due.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_lock_result due;
        if (!i_rst_n) begin
            writer_locked = 1'b0;
            owner_tid     = '0;
            reader_holds  = '0;
            waiting_readers.delete();
            waiting_writers.delete();
            results_due.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                predict_lock_request(i_req_user, rwl_pkg::t_tid'(i_req_data));
            if (i_res_valid && i_res_ready) begin
                beats_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat: thread %0d event %0d last %0d",
                                              i_res_data, i_res_user, i_res_last));
                end else begin
                    due = results_due.pop_front();
                    if (i_res_data !== due.target)
                        report_mismatch($sformatf("target_thread: got %0d, expected %0d",
                                                  i_res_data, due.target));
                    if (i_res_user !== due.ev)
                        report_mismatch($sformatf("event_res for thread %0d: got %0d, expected %0d",
                                                  due.target, i_res_user, due.ev));
                    if (i_res_last !== due.last)
                        report_mismatch($sformatf("last for thread %0d: got %0d, expected %0d",
                                                  due.target, i_res_last, due.last));
                end
            end
        end
        o_pending     <= results_due.size();
        o_writer_held <= writer_locked;
        o_owner       <= owner_tid;
    end

endmodule

### tb/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 320;
    localparam int LONG_HOLD    = 300;   // output stall used to back the block up
    localparam int TAIL_CYCLES  = 40;    // idle tail after the last result, sized for the worst release
    localparam int IDLE_LIMIT   = 4000;  // cycles without any beat before giving up

    // the one kind code the block has no name for: it must be dropped silently
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    logic [7:0]    req_data;     // [7:0] thread_id
    logic [1:0]    req_user;     // [1:0] kind
    logic          res_valid;
    logic          res_ready;
    logic [7:0]    res_data;     // [7:0] target_thread
    logic [2:0]    res_user;     // [2:0] event_res
    logic          res_last;

    int            mismatches;
    int            results_pending;
    int            beats_checked;
    logic          lock_writer_held;
    rwl_pkg::t_tid lock_owner;

    // handshake between the stimulus and the output-stall process
    bit   long_hold_req = 1'b0;
    int   no_gap_left   = 0;
    int   sent_by_kind[4];

    always #(CLK_PERIOD / 2) clk = ~clk;

    reader_writer_lock_arbiter_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_user),
        .o_m_axis_tlast  (res_last)
    );

    rwl_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_req_user    (req_user),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .i_res_user    (res_user),
        .i_res_last    (res_last),
        .o_mismatches  (mismatches),
        .o_pending     (results_pending),
        .o_beats       (beats_checked),
        .o_writer_held (lock_writer_held),
        .o_owner       (lock_owner)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // offer one request beat and wait for its acceptance
    task automatic send_request(input logic [1:0] kind, input logic [7:0] tid);
        int gap;
        if (no_gap_left > 0) begin
            gap = 0;
            no_gap_left--;
        end else begin
            gap = pick_gap();
            // now and then a stretch with no idling at all
            if ($urandom_range(0, 49) == 0)
                no_gap_left = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_user  <= kind;
        req_data  <= tid;
        do @(posedge clk); while (!req_ready);
        sent_by_kind[kind]++;
    endtask

    // stop offering until every predicted beat has come out
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
    endtask

    // output side: random stalls, calm stretches, and the long hold on request
    initial begin : result_sink
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left  = 0;
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                res_ready <= 1'b0;
                stall_left--;
            end else if (calm_left > 0) begin
                res_ready <= 1'b1;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    res_ready <= 1'b1;
                end else if (r < 65) begin
                    res_ready <= 1'b1;
                    calm_left = $urandom_range(20, 60);
                end else begin
                    res_ready <= 1'b0;
                    if (r < 90)
                        stall_left = $urandom_range(0, 2);
                    else if (r < 98)
                        stall_left = $urandom_range(3, 11);
                    else
                        stall_left = $urandom_range(19, 39);
                end
            end
        end
    end

    // watchdog: any beat on either side resets the idle count
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] timeout: no beat for %0d cycles, %0d results still due",
                 $time, IDLE_LIMIT, results_pending);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        logic [1:0] kind;
        logic [7:0] tid;
        int         counted;
        int         r;
        int         total;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        req_user  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed corners ----
        send_request(rwl_pkg::KIND_RD, 8'h00);    // read granted, lowest thread id
        send_request(rwl_pkg::KIND_RD, 8'hFF);    // read granted, highest thread id
        send_request(rwl_pkg::KIND_WR, 8'h5A);    // readers hold: writer waits
        send_request(rwl_pkg::KIND_REL, 8'h00);   // a reader remains: no handoff to the writer
        send_request(rwl_pkg::KIND_REL, 8'hFF);   // last reader out: writer takes over
        send_request(rwl_pkg::KIND_RD, 8'h11);    // writer holds: reader waits
        send_request(rwl_pkg::KIND_WR, 8'hA5);    // writer holds: writer waits
        send_request(rwl_pkg::KIND_REL, 8'h33);   // not the owner, no readers: release error
        send_request(rwl_pkg::KIND_REL, 8'h5A);   // waiting writer served before waiting reader
        send_request(rwl_pkg::KIND_REL, 8'hA5);   // no writer left: waiting reader granted
        send_request(rwl_pkg::KIND_REL, 8'h11);   // lock now free, nothing to hand over
        send_request(rwl_pkg::KIND_REL, 8'h00);   // release of a free lock
        send_request(KIND_UNUSED, 8'hFF);         // unused kind, dropped
        send_request(rwl_pkg::KIND_WR, 8'hFF);    // free lock: writer granted at once
        send_request(rwl_pkg::KIND_RD, 8'h00);
        send_request(KIND_UNUSED, 8'h00);
        send_request(rwl_pkg::KIND_REL, 8'hFF);
        send_request(rwl_pkg::KIND_REL, 8'h00);
        wait_for_results();

        // ---- full wait queues under a long output stall ----
        // the sink holds off while requests keep coming, so the block backs up
        long_hold_req = 1'b1;
        no_gap_left   = 80;
        send_request(rwl_pkg::KIND_WR, 8'hC0);
        for (int i = 0; i <= rwl_pkg::QUEUE_DEPTH; i++)
            send_request(rwl_pkg::KIND_RD, 8'(8'h40 + i));   // the last one finds the queue full
        for (int i = 0; i <= rwl_pkg::QUEUE_DEPTH; i++)
            send_request(rwl_pkg::KIND_WR, 8'(8'h80 + i));   // same for the writer queue
        // owner chain: each release hands the lock to the next queued writer
        send_request(rwl_pkg::KIND_REL, 8'hC0);
        for (int i = 0; i < rwl_pkg::QUEUE_DEPTH; i++)
            send_request(rwl_pkg::KIND_REL, 8'(8'h80 + i));  // the last wakes all sixteen readers
        for (int i = 0; i < rwl_pkg::QUEUE_DEPTH; i++)
            send_request(rwl_pkg::KIND_REL, 8'(8'h40 + i));
        wait_for_results();

        // ---- random traffic ----
        // mostly sensible: the owner releases what it holds; some noise mixed in
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r   = $urandom_range(0, 99);
            tid = 8'($urandom_range(0, 255));
            if (r < 5) begin
                kind = KIND_UNUSED;
            end else if (r < 13) begin
                kind = 2'($urandom_range(0, 2));
            end else if (lock_writer_held) begin
                if (r < 45) begin
                    kind = rwl_pkg::KIND_REL;
                    tid  = lock_owner;
                end else if (r < 75) begin
                    kind = rwl_pkg::KIND_RD;
                end else begin
                    kind = rwl_pkg::KIND_WR;
                end
            end else begin
                if (r < 48)
                    kind = rwl_pkg::KIND_RD;
                else if (r < 61)
                    kind = rwl_pkg::KIND_WR;
                else
                    kind = rwl_pkg::KIND_REL;
            end
            send_request(kind, tid);
            if (kind != KIND_UNUSED)
                counted++;
            // occasional full pause mid-run
            if ($urandom_range(0, 119) == 0)
                wait_for_results();
        end

        // ---- wind down ----
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        total = sent_by_kind[rwl_pkg::KIND_RD] + sent_by_kind[rwl_pkg::KIND_WR]
                + sent_by_kind[rwl_pkg::KIND_REL] + sent_by_kind[KIND_UNUSED];
        $display("Run covered %0d requests (%0d read, %0d write, %0d release, %0d unused kind)",
                 total, sent_by_kind[rwl_pkg::KIND_RD], sent_by_kind[rwl_pkg::KIND_WR],
                 sent_by_kind[rwl_pkg::KIND_REL], sent_by_kind[KIND_UNUSED]);
        $display("%0d result beats checked over corner cases, full queues under a long stall, %s",
                 beats_checked, "and random traffic");
        if (mismatches == 0 && results_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
